>>> hw/rtl/ptdg_pkg.sv
package ptdg_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_APPLY = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [5:0] RANKS_PER_SUIT = 6'd13;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] perm_slot;
    logic [5:0] position;
    logic [5:0] source;
  } in_word_t;

  typedef struct packed {
    logic [5:0] card;
    logic [3:0] rank;
    logic [1:0] suit;
    logic       last;
  } out_word_t;

  // card below 64, so four compare-subtract steps leave the remainder
  function automatic logic [3:0] card_rank(input logic [5:0] c);
    logic [5:0] r;
    r = c;
    for (int k = 0; k < 4; k++) begin
      if (r >= RANKS_PER_SUIT) r = r - RANKS_PER_SUIT;
    end
    return r[3:0];
  endfunction

  function automatic logic [1:0] card_suit(input logic [5:0] c);
    logic [5:0] r;
    logic [2:0] q;
    r = c;
    q = 3'd0;
    for (int k = 0; k < 4; k++) begin
      if (r >= RANKS_PER_SUIT) begin
        r = r - RANKS_PER_SUIT;
        q = q + 3'd1;
      end
    end
    return q[1:0];
  endfunction

endpackage

>>> hw/rtl/permutation_table_deck_gather.sv
// Load and deck reset: the block stays idle, the next word is taken in the following cycle.
// Apply: one entry a cycle through the permutation memory read,
//   the deck memory read and the write into the other buffer.
// Readout: DECK_SIZE result words, one a cycle while the output is not stalled,
//   via the deck read and output registers; busy until the last word is taken.
// Reset: deck returns to identity at once through per-entry valid bits; the
//   permutation memory is not cleared and holds garbage until loaded.
module permutation_table_deck_gather #(
  parameter int DECK_SIZE  = 52,
  parameter int PERM_SLOTS = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ptdg_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ptdg_pkg::out_word_t  out_word_o
);

  localparam int IDX_W   = $clog2(DECK_SIZE);
  localparam int PDEPTH  = PERM_SLOTS * DECK_SIZE;
  localparam int PA_W    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int DDEPTH  = 2 * DECK_SIZE;
  localparam int DA_W    = $clog2(DDEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DECK_SIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_APPLY = 3'b010,
    ST_READ  = 3'b100
  } state_e;

  function automatic logic [DA_W-1:0] deck_addr(input logic sel, input logic [IDX_W-1:0] idx);
    return sel ? (DA_W'(idx) + DA_W'(DECK_SIZE)) : DA_W'(idx);
  endfunction

  state_e            state_q;
  logic [IDX_W-1:0]  cnt_q;
  logic              iss_q;
  logic [PA_W-1:0]   base_q;
  logic              fsel_q;
  logic [DDEPTH-1:0] dvld_q;

  logic              a1_vld_q, a2_vld_q;
  logic [IDX_W-1:0]  a1_idx_q, a2_idx_q;

  logic [IDX_W-1:0]  perm_mem [PDEPTH];
  logic [IDX_W-1:0]  pm_rdata_q;
  logic [IDX_W-1:0]  deck_mem [DDEPTH];
  logic [IDX_W-1:0]  drd_data_q, drd_idx_q;
  logic              drd_hit_q;

  logic              rd_vld_q, rd_last_q;
  logic              out_vld_q;
  ptdg_pkg::out_word_t out_word_q;

  logic              in_acc, slot_ok, ent_ok, pm_we;
  logic [PA_W-1:0]   base, pm_waddr;
  logic              a_iss, r_iss, mv, out_acc, last_iss;
  logic              drd_en, d_we;
  logic [IDX_W-1:0]  from, drd_idx, dval;
  logic [DA_W-1:0]   drd_addr, d_waddr;
  logic [5:0]        card;

  always_comb begin
    in_acc   = in_valid_i && (state_q == ST_IDLE);
    slot_ok  = 11'(in_word_i.perm_slot) < 11'(PERM_SLOTS);
    ent_ok   = (7'(in_word_i.position) < 7'(DECK_SIZE)) &&
               (7'(in_word_i.source) < 7'(DECK_SIZE));
    base     = PA_W'(in_word_i.perm_slot) * PA_W'(DECK_SIZE);
    pm_waddr = base + PA_W'(in_word_i.position);
    pm_we    = in_acc && (in_word_i.action == ptdg_pkg::ACT_LOAD) && slot_ok && ent_ok;

    out_acc  = out_vld_q && !out_stall_i;
    mv       = rd_vld_q && (!out_vld_q || !out_stall_i);
    a_iss    = (state_q == ST_APPLY) && iss_q;
    r_iss    = (state_q == ST_READ) && iss_q && (!rd_vld_q || mv);
    last_iss = cnt_q == LAST_IDX;

    // stored sources are always in range once loaded; guard anyway
    from     = (7'(pm_rdata_q) < 7'(DECK_SIZE)) ? pm_rdata_q : '0;
    drd_en   = a1_vld_q || r_iss;
    drd_idx  = a1_vld_q ? from : cnt_q;
    drd_addr = deck_addr(fsel_q, drd_idx);
    dval     = drd_hit_q ? drd_data_q : drd_idx_q;

    d_we     = a2_vld_q;
    d_waddr  = deck_addr(!fsel_q, a2_idx_q);
    card     = 6'(dval);
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) perm_mem[pm_waddr] <= IDX_W'(in_word_i.source);
    if (a_iss) pm_rdata_q <= perm_mem[base_q + PA_W'(cnt_q)];
  end

  always_ff @(posedge clk_i) begin
    if (d_we) deck_mem[d_waddr] <= dval;
    if (drd_en) begin
      drd_data_q <= deck_mem[drd_addr];
      drd_idx_q  <= drd_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv) begin
      out_word_q.card <= card;
      out_word_q.rank <= ptdg_pkg::card_rank(card);
      out_word_q.suit <= ptdg_pkg::card_suit(card);
      out_word_q.last <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      iss_q     <= 1'b0;
      base_q    <= '0;
      fsel_q    <= 1'b0;
      dvld_q    <= '0;
      a1_vld_q  <= 1'b0;
      a2_vld_q  <= 1'b0;
      a1_idx_q  <= '0;
      a2_idx_q  <= '0;
      drd_hit_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      a1_vld_q <= a_iss;
      a1_idx_q <= cnt_q;
      a2_vld_q <= a1_vld_q;
      a2_idx_q <= a1_idx_q;
      if (drd_en) drd_hit_q <= dvld_q[drd_addr];
      if (d_we) dvld_q[d_waddr] <= 1'b1;

      if (a_iss || r_iss) begin
        cnt_q <= cnt_q + IDX_W'(1);
        if (last_iss) iss_q <= 1'b0;
      end
      if (r_iss) begin
        rd_vld_q  <= 1'b1;
        rd_last_q <= last_iss;
      end else if (mv) begin
        rd_vld_q <= 1'b0;
      end
      if (mv) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_word_i.action)
              ptdg_pkg::ACT_RESET: begin
                dvld_q <= '0;
                fsel_q <= 1'b0;
              end
              ptdg_pkg::ACT_APPLY: begin
                if (slot_ok) begin
                  state_q <= ST_APPLY;
                  base_q  <= base;
                  cnt_q   <= '0;
                  iss_q   <= 1'b1;
                end
              end
              ptdg_pkg::ACT_READ: begin
                state_q <= ST_READ;
                cnt_q   <= '0;
                iss_q   <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_APPLY: begin
          if (a2_vld_q && (a2_idx_q == LAST_IDX)) begin
            fsel_q  <= !fsel_q;
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (out_acc && out_word_q.last) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

>>> hw/rtl/ptdg_checker.sv
module ptdg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input ptdg_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ptdg_pkg::out_word_t out_word_o
);

  // no new word is taken while a readout is being delivered
  a_busy_during_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted during readout");

  // load and deck reset leave the block free to take a word in the next cycle
  a_short_actions: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o &&
     (in_word_i.action == ptdg_pkg::ACT_LOAD || in_word_i.action == ptdg_pkg::ACT_RESET))
    |=> !in_stall_o)
    else $error("load or reset left the block busy");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_word_i.action == ptdg_pkg::ACT_READ) |=> in_stall_o)
    else $error("readout did not hold off input");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_word_o.last) |=> !out_valid_o)
    else $error("word after last of readout");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled output word changed");

endmodule

bind permutation_table_deck_gather ptdg_checker u_ptdg_checker (.*);

>>> dv/permutation_table_deck_gather_checker.sv
module permutation_table_deck_gather_checker #(
  parameter int DECK_SIZE  = 52,
  parameter int PERM_SLOTS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ptdg_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ptdg_pkg::out_word_t out_word_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  cards_seen_o
);

  localparam int CARDS_PER_SUIT = 13;
  localparam int MAX_REPORTS    = 10;

  logic [5:0]          deck_buf [2][DECK_SIZE];
  bit                  front_sel;
  logic [5:0]          perm_tab [PERM_SLOTS][DECK_SIZE];
  ptdg_pkg::out_word_t due_cards [$];

  task automatic restack();
    for (int i = 0; i < DECK_SIZE; i++) begin
      deck_buf[0][i] = 6'(i);
      deck_buf[1][i] = 6'(i);
    end
    front_sel = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    ptdg_pkg::out_word_t want;
    logic [5:0]          c;
    int                  src_pos;
    if (!rst_ni) begin
      restack();
      due_cards.delete();
      fail_count_o = 0;
      pending_o    = 0;
      cards_seen_o = 0;
    end else begin
      // result side first: a readout's first word never leaves on its own edge
      if (out_valid_i && !out_stall_i) begin
        cards_seen_o++;
        if (due_cards.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS) begin
            $display("card word %0d unexpected: card %0d rank %0d suit %0d last %0d",
                     cards_seen_o, out_word_i.card, out_word_i.rank, out_word_i.suit,
                     out_word_i.last);
          end
        end else begin
          want = due_cards.pop_front();
          if (out_word_i.card !== want.card || out_word_i.rank !== want.rank ||
              out_word_i.suit !== want.suit || out_word_i.last !== want.last) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS) begin
              $display("card word %0d: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                       cards_seen_o, want.card, want.rank, want.suit, want.last,
                       out_word_i.card, out_word_i.rank, out_word_i.suit, out_word_i.last);
            end
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        case (in_word_i.action)
          ptdg_pkg::ACT_LOAD: begin
            if (in_word_i.perm_slot < PERM_SLOTS && in_word_i.position < DECK_SIZE &&
                in_word_i.source < DECK_SIZE) begin
              perm_tab[in_word_i.perm_slot][in_word_i.position] = in_word_i.source;
            end
          end
          ptdg_pkg::ACT_RESET: begin
            restack();
          end
          ptdg_pkg::ACT_APPLY: begin
            if (in_word_i.perm_slot < PERM_SLOTS) begin
              // gather into the idle buffer, then swap
              for (int i = 0; i < DECK_SIZE; i++) begin
                src_pos = int'(perm_tab[in_word_i.perm_slot][i]);
                if (src_pos >= DECK_SIZE) src_pos = 0;
                deck_buf[!front_sel][i] = deck_buf[front_sel][src_pos];
              end
              front_sel = !front_sel;
            end
          end
          default: begin
            for (int i = 0; i < DECK_SIZE; i++) begin
              c         = deck_buf[front_sel][i];
              want.card = c;
              want.rank = 4'(c % CARDS_PER_SUIT);
              want.suit = 2'(c / CARDS_PER_SUIT);
              want.last = (i == DECK_SIZE - 1);
              due_cards = {due_cards, want};
            end
          end
        endcase
      end
      pending_o = due_cards.size();
    end
  end

endmodule

>>> dv/permutation_table_deck_gather_test.sv
module permutation_table_deck_gather_test;

  localparam int DECK_SIZE    = 52;
  localparam int PERM_SLOTS   = 128;
  localparam int ITEM_TARGET  = 130;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                out_stall_i = 1'b0;
  ptdg_pkg::in_word_t  in_word_i   = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  ptdg_pkg::out_word_t out_word_o;

  int fail_count;
  int pending;
  int cards_seen;
  int cycle_count = 0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic holding        = 1'b0;
  event long_hold;

  bit [DECK_SIZE-1:0] entry_written [PERM_SLOTS];
  int full_slots [$];
  int words_counted = 0;
  int loads_done    = 0;
  int applies_done  = 0;
  int resets_done   = 0;
  int readouts_done = 0;

  permutation_table_deck_gather #(
    .DECK_SIZE  (DECK_SIZE),
    .PERM_SLOTS (PERM_SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  permutation_table_deck_gather_checker #(
    .DECK_SIZE  (DECK_SIZE),
    .PERM_SLOTS (PERM_SLOTS)
  ) card_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_i   (out_word_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .cards_seen_o (cards_seen)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= holding || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off, counted here so the block backs up into its input
  initial begin
    forever begin
      @(long_hold);
      holding <= 1'b1;
      for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk_i);
      holding <= 1'b0;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timed out after %0d cycles with %0d card words outstanding",
             cycle_count, pending);
    $display("CHECK FAILED");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [1:0] act, input int slot, input int pos,
                           input int src);
    ptdg_pkg::in_word_t w;
    bit                 ignored;
    bit                 was_full;
    w.action    = act;
    w.perm_slot = 7'(slot);
    w.position  = 6'(pos);
    w.source    = 6'(src);
    ignored = (act == ptdg_pkg::ACT_LOAD) && (pos >= DECK_SIZE || src >= DECK_SIZE);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (!ignored) words_counted++;
    case (act)
      ptdg_pkg::ACT_LOAD: begin
        if (!ignored) begin
          was_full = &entry_written[slot];
          entry_written[slot][pos] = 1'b1;
          if (!was_full && &entry_written[slot]) full_slots = {full_slots, slot};
          loads_done++;
        end
      end
      ptdg_pkg::ACT_RESET: resets_done++;
      ptdg_pkg::ACT_APPLY: applies_done++;
      default:             readouts_done++;
    endcase
  endtask

  // whole permutation in random position order; a shuffle, or any sources at all
  task automatic load_shuffle(input int slot, input bit shuffled);
    int order [DECK_SIZE];
    int srcs  [DECK_SIZE];
    int j;
    int t;
    for (int i = 0; i < DECK_SIZE; i++) begin
      order[i] = i;
      srcs[i]  = shuffled ? i : $urandom_range(DECK_SIZE - 1);
    end
    for (int i = DECK_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i]; order[i] = order[j]; order[j] = t;
      j = $urandom_range(i);
      t = srcs[i]; srcs[i] = srcs[j]; srcs[j] = t;
    end
    for (int i = 0; i < DECK_SIZE; i++) begin
      send_word(ptdg_pkg::ACT_LOAD, slot, order[i], srcs[order[i]]);
    end
  endtask

  task automatic play_round();
    int pick;
    int slot;
    pick = $urandom_range(9);
    if (full_slots.size() == 0 || pick == 0) begin
      load_shuffle($urandom_range(PERM_SLOTS - 1), $urandom_range(3) != 0);
    end else if (pick <= 6) begin
      // tweak a loaded permutation, apply a few, read the deck back
      slot = full_slots[$urandom_range(full_slots.size() - 1)];
      repeat ($urandom_range(4)) begin
        send_word(ptdg_pkg::ACT_LOAD, slot, $urandom_range(DECK_SIZE - 1),
                  $urandom_range(DECK_SIZE - 1));
      end
      if ($urandom_range(5) == 0) begin
        send_word(ptdg_pkg::ACT_RESET, $urandom_range(PERM_SLOTS - 1),
                  $urandom_range(63), $urandom_range(63));
      end
      send_word(ptdg_pkg::ACT_APPLY, slot, $urandom_range(63), $urandom_range(63));
      repeat ($urandom_range(2)) begin
        send_word(ptdg_pkg::ACT_APPLY, full_slots[$urandom_range(full_slots.size() - 1)],
                  $urandom_range(63), $urandom_range(63));
      end
      send_word(ptdg_pkg::ACT_READ, $urandom_range(PERM_SLOTS - 1), $urandom_range(63),
                $urandom_range(63));
    end else if (pick == 7) begin
      send_word(ptdg_pkg::ACT_RESET, $urandom_range(PERM_SLOTS - 1), $urandom_range(63),
                $urandom_range(63));
      send_word(ptdg_pkg::ACT_READ, $urandom_range(PERM_SLOTS - 1), $urandom_range(63),
                $urandom_range(63));
    end else begin
      // stray loads, some out of range and dropped by the block
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(1)) begin
          send_word(ptdg_pkg::ACT_LOAD, $urandom_range(PERM_SLOTS - 1),
                    $urandom_range(DECK_SIZE, 63), $urandom_range(63));
        end else begin
          send_word(ptdg_pkg::ACT_LOAD, $urandom_range(PERM_SLOTS - 1),
                    $urandom_range(DECK_SIZE - 1), $urandom_range(DECK_SIZE - 1));
        end
      end
    end
  endtask

  initial begin : stimulus
    int send_pct [4];
    int recv_pct [4];
    int base;
    send_pct = '{0, 82, 0, 11};
    recv_pct = '{0, 0, 82, 11};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // identity deck read while the receiver holds off; later words back up
    -> long_hold;
    send_word(ptdg_pkg::ACT_READ, 0, 0, 0);
    send_word(ptdg_pkg::ACT_LOAD, 0, 0, 51);
    send_word(ptdg_pkg::ACT_LOAD, 127, 51, 0);
    send_word(ptdg_pkg::ACT_LOAD, 127, 63, 5);
    send_word(ptdg_pkg::ACT_LOAD, 64, 5, 63);
    send_word(ptdg_pkg::ACT_LOAD, 1, 52, 52);
    send_word(ptdg_pkg::ACT_LOAD, 127, 0, 51);
    send_word(ptdg_pkg::ACT_LOAD, 0, 63, 63);
    send_word(ptdg_pkg::ACT_READ, 127, 63, 63);
    send_word(ptdg_pkg::ACT_RESET, 127, 63, 63);
    send_word(ptdg_pkg::ACT_READ, 0, 0, 0);

    base = words_counted;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      do play_round(); while (words_counted - base < (p + 1) * ITEM_TARGET / 4);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("%0d words in: %0d loads, %0d applies, %0d deck resets, %0d readouts",
             words_counted, loads_done, applies_done, resets_done, readouts_done);
    $display("%0d card words checked over %0d cycles, %0d permutations fully loaded",
             cards_seen, cycle_count, full_slots.size());
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d card words outstanding", fail_count, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
